// ===== rtl/core/sbpb_pkg.sv =====
// package: types, constants and the read length table of the servo packet builder
`timescale 1ns / 1ps

package sbpb_pkg;

  // command codes
  typedef enum logic [2:0] {
    OP_READ_REG   = 3'd0,
    OP_WRITE_BYTE = 3'd1,
    OP_WRITE_WORD = 3'd2,
    OP_WHEEL_MODE = 3'd3,
    OP_JOINT_MODE = 3'd4,
    OP_SPEED      = 3'd5
  } op_e;

  // packet bytes and instruction codes
  localparam logic [7:0] PKT_START         = 8'hFF;
  localparam logic [7:0] INS_READ          = 8'h02;
  localparam logic [7:0] INS_WRITE         = 8'h03;
  localparam logic [7:0] ADDR_ANGLE_LIMITS = 8'h06;
  localparam logic [7:0] ADDR_MOVING_SPEED = 8'h20;

  // body lengths and packet sizes
  localparam int unsigned BODY_MAX = 9;
  localparam int unsigned PKT_MAX  = 11;
  localparam logic [7:0] LEN_ONE_PARAM  = 8'd4;
  localparam logic [7:0] LEN_TWO_PARAM  = 8'd5;
  localparam logic [7:0] LEN_FOUR_PARAM = 8'd7;
  localparam logic [3:0] BODY_ONE_PARAM  = 4'd5;
  localparam logic [3:0] BODY_TWO_PARAM  = 4'd6;
  localparam logic [3:0] BODY_FOUR_PARAM = 4'd8;
  localparam logic [3:0] PKT_IDX_ONE  = 4'd7;
  localparam logic [3:0] PKT_IDX_TWO  = 4'd8;
  localparam logic [3:0] PKT_IDX_FOUR = 4'd10;

  // latched command
  typedef struct packed {
    logic [2:0]         op;
    logic [7:0]         servo_id;
    logic [7:0]         reg_addr;
    logic [15:0]        value;
    logic signed [15:0] cw_limit;
    logic [15:0]        ccw_limit;
  } cmd_t;

  // finished packet handed to the serializer
  typedef struct packed {
    logic                        has_bytes;
    logic [3:0]                  last_idx;
    logic [PKT_MAX-1:0][7:0]     bytes;
  } pkt_t;

  // read length of a control table entry, zero for unknown addresses
  function automatic logic [7:0] read_len(input logic [7:0] addr);
    logic [7:0] len;
    case (addr) inside
      8'h00, 8'h06, 8'h08, 8'h0E, 8'h1E, 8'h20, 8'h22, 8'h24, 8'h26, 8'h28,
      8'h30: len = 8'd2;
      8'h02, 8'h03, 8'h04, 8'h05, 8'h0B, 8'h0C, 8'h0D, 8'h10, 8'h11, 8'h12,
      8'h18, 8'h19, 8'h1A, 8'h1B, 8'h1C, 8'h1D, 8'h2A, 8'h2B, 8'h2C, 8'h2E,
      8'h2F: len = 8'd1;
      default: len = 8'd0;
    endcase
    return len;
  endfunction

endpackage

// ===== rtl/core/sbpb_cmd_if.sv =====
// interface: command channel into the packet builder
`timescale 1ns / 1ps

interface sbpb_cmd_if;
  logic               valid;
  logic               ready;
  logic [2:0]         op;
  logic [7:0]         servo_id;
  logic [7:0]         reg_addr;
  logic [15:0]        value;
  logic signed [15:0] cw_limit;
  logic [15:0]        ccw_limit;

  modport source (
    output valid, op, servo_id, reg_addr, value, cw_limit, ccw_limit,
    input  ready
  );
  modport sink (
    input  valid, op, servo_id, reg_addr, value, cw_limit, ccw_limit,
    output ready
  );
endinterface

// ===== rtl/core/sbpb_byte_if.sv =====
// interface: packet byte channel out of the packet builder
`timescale 1ns / 1ps

interface sbpb_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] tx_byte;
  logic       last_byte;

  modport source (
    output valid, tx_byte, last_byte,
    input  ready
  );
  modport sink (
    input  valid, tx_byte, last_byte,
    output ready
  );
endinterface

// ===== rtl/core/sbpb_builder.sv =====
// command register, mode flag and packet assembly
`timescale 1ns / 1ps

module sbpb_builder
  import sbpb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  sbpb_cmd_if.sink    cmd_i,
  output pkt_t        pkt_o,
  output logic        pkt_vld_o,
  input  logic        pkt_take_i
);

  logic                     cmd_vld_q, cmd_vld_d;
  cmd_t                     cmd_q, cmd_d;
  logic                     joint_q, joint_d;
  logic                     cmd_acc;
  logic [BODY_MAX-1:0][7:0] body;
  logic [3:0]               body_n;
  logic [3:0]               last_idx;
  logic                     has_bytes;
  logic [7:0]               sum;
  logic [7:0]               csum;
  logic [15:0]              cw_clamped;
  logic [10:0]              speed;

  // command register, refilled as soon as its packet moves on
  assign cmd_i.ready = !cmd_vld_q || pkt_take_i;
  assign cmd_acc     = cmd_i.valid && cmd_i.ready;

  always_comb begin
    cmd_vld_d = cmd_vld_q;
    cmd_d     = cmd_q;
    if (pkt_take_i) begin
      cmd_vld_d = 1'b0;
    end
    if (cmd_acc) begin
      cmd_vld_d       = 1'b1;
      cmd_d.op        = cmd_i.op;
      cmd_d.servo_id  = cmd_i.servo_id;
      cmd_d.reg_addr  = cmd_i.reg_addr;
      cmd_d.value     = cmd_i.value;
      cmd_d.cw_limit  = cmd_i.cw_limit;
      cmd_d.ccw_limit = cmd_i.ccw_limit;
    end
  end

  // mode flag follows wheel and joint commands as their packets leave
  always_comb begin
    joint_d = joint_q;
    if (pkt_take_i) begin
      case (op_e'(cmd_q.op))
        OP_WHEEL_MODE: joint_d = 1'b0;
        OP_JOINT_MODE: joint_d = 1'b1;
        default:       joint_d = joint_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_vld_q <= 1'b0;
      joint_q   <= 1'b0;
    end else begin
      cmd_vld_q <= cmd_vld_d;
      joint_q   <= joint_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
  end

  // limit and speed reduction
  assign cw_clamped = cmd_q.cw_limit[15] ? 16'd0 : cmd_q.cw_limit;
  assign speed      = joint_q ? {1'b0, cmd_q.value[9:0]} : cmd_q.value[10:0];

  // packet body per command
  always_comb begin
    body      = '0;
    body[0]   = cmd_q.servo_id;
    body_n    = BODY_ONE_PARAM;
    last_idx  = PKT_IDX_ONE;
    has_bytes = 1'b1;
    case (op_e'(cmd_q.op))
      OP_READ_REG: begin
        body[1] = LEN_ONE_PARAM;
        body[2] = INS_READ;
        body[3] = cmd_q.reg_addr;
        body[4] = read_len(cmd_q.reg_addr);
      end
      OP_WRITE_BYTE: begin
        body[1] = LEN_ONE_PARAM;
        body[2] = INS_WRITE;
        body[3] = cmd_q.reg_addr;
        body[4] = cmd_q.value[7:0];
      end
      OP_WRITE_WORD: begin
        body[1]  = LEN_TWO_PARAM;
        body[2]  = INS_WRITE;
        body[3]  = cmd_q.reg_addr;
        body[4]  = cmd_q.value[7:0];
        body[5]  = cmd_q.value[15:8];
        body_n   = BODY_TWO_PARAM;
        last_idx = PKT_IDX_TWO;
      end
      OP_WHEEL_MODE: begin
        body[1]  = LEN_FOUR_PARAM;
        body[2]  = INS_WRITE;
        body[3]  = ADDR_ANGLE_LIMITS;
        body_n   = BODY_FOUR_PARAM;
        last_idx = PKT_IDX_FOUR;
      end
      OP_JOINT_MODE: begin
        body[1]  = LEN_FOUR_PARAM;
        body[2]  = INS_WRITE;
        body[3]  = ADDR_ANGLE_LIMITS;
        body[4]  = cw_clamped[7:0];
        body[5]  = cw_clamped[15:8];
        body[6]  = cmd_q.ccw_limit[7:0];
        body[7]  = {6'd0, cmd_q.ccw_limit[9:8]};
        body_n   = BODY_FOUR_PARAM;
        last_idx = PKT_IDX_FOUR;
      end
      OP_SPEED: begin
        body[1]  = LEN_TWO_PARAM;
        body[2]  = INS_WRITE;
        body[3]  = ADDR_MOVING_SPEED;
        body[4]  = speed[7:0];
        body[5]  = {5'd0, speed[10:8]};
        body_n   = BODY_TWO_PARAM;
        last_idx = PKT_IDX_TWO;
      end
      default: begin
        has_bytes = 1'b0;
      end
    endcase
  end

  // checksum over the body, unused slots are zero
  always_comb begin
    sum = '0;
    for (int i = 0; i < BODY_MAX; i++) begin
      sum = sum + body[i];
    end
    csum = ~sum;
  end

  // frame: two start bytes, body, checksum
  always_comb begin
    pkt_o           = '0;
    pkt_o.has_bytes = has_bytes;
    pkt_o.last_idx  = last_idx;
    pkt_o.bytes[0]  = PKT_START;
    pkt_o.bytes[1]  = PKT_START;
    for (int i = 0; i < BODY_MAX; i++) begin
      pkt_o.bytes[i+2] = (4'(i) < body_n) ? body[i] : csum;
    end
  end

  assign pkt_vld_o = cmd_vld_q;

endmodule

// ===== rtl/core/sbpb_serializer.sv =====
// packet buffer and byte-wise output register
`timescale 1ns / 1ps

module sbpb_serializer
  import sbpb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  pkt_t        pkt_i,
  input  logic        pkt_vld_i,
  output logic        pkt_take_o,
  sbpb_byte_if.source tx_o
);

  pkt_t       pkt_q, pkt_d;
  logic [3:0] idx_q, idx_d;
  logic       busy_q, busy_d;
  logic       out_vld_q, out_vld_d;
  logic [7:0] out_byte_q, out_byte_d;
  logic       out_last_q, out_last_d;
  logic       adv;
  logic       final_byte;

  // output register free or drained this cycle
  assign adv        = !out_vld_q || tx_o.ready;
  assign final_byte = busy_q && adv && (idx_q == pkt_q.last_idx);
  assign pkt_take_o = pkt_vld_i && (!busy_q || final_byte);

  // byte stepping and packet reload
  always_comb begin
    pkt_d      = pkt_q;
    idx_d      = idx_q;
    busy_d     = busy_q;
    out_vld_d  = out_vld_q;
    out_byte_d = out_byte_q;
    out_last_d = out_last_q;
    if (adv) begin
      out_vld_d = busy_q;
      if (busy_q) begin
        out_byte_d = pkt_q.bytes[idx_q];
        out_last_d = (idx_q == pkt_q.last_idx);
        idx_d      = idx_q + 4'd1;
        if (idx_q == pkt_q.last_idx) begin
          busy_d = 1'b0;
        end
      end
    end
    if (pkt_take_o) begin
      pkt_d  = pkt_i;
      idx_d  = '0;
      busy_d = pkt_i.has_bytes;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      out_vld_q <= 1'b0;
      idx_q     <= '0;
    end else begin
      busy_q    <= busy_d;
      out_vld_q <= out_vld_d;
      idx_q     <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pkt_q      <= pkt_d;
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
  end

  assign tx_o.valid     = out_vld_q;
  assign tx_o.tx_byte   = out_byte_q;
  assign tx_o.last_byte = out_last_q;

  // the byte index never runs past the checksum
  a_idx_in_packet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> idx_q <= pkt_q.last_idx)
    else $error("byte index past end of packet");

  // a live packet has one of the three legal sizes
  a_pkt_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (pkt_q.last_idx == PKT_IDX_ONE || pkt_q.last_idx == PKT_IDX_TWO ||
                pkt_q.last_idx == PKT_IDX_FOUR))
    else $error("packet size out of range");

  // packets are at least eight bytes, so two ends never follow each other
  a_no_back_to_back_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tx_o.valid && tx_o.ready && tx_o.last_byte |=> !(tx_o.valid && tx_o.last_byte))
    else $error("packet end right after packet end");

endmodule

// ===== rtl/core/servo_bus_instruction_packet_builder.sv =====
// top level: servo bus instruction packet builder
// Takes one servo command on cmd_i (valid/ready) and sends its instruction
// packet on tx_o one byte per item: two start bytes, id, length,
// instruction, address, parameters and the checksum, which is flagged by
// last_byte. A packet is 8, 9 or 11 bytes; codes 6 and 7 give no bytes.
// The first byte of a packet passes the command register, the packet buffer
// and the byte output register. Throughput: one byte per cycle while tx_o is
// ready, set by the single byte output register; the next command is
// accepted while the current packet drains and its first byte follows the
// previous checksum with no gap.
// Reset clears the command, packet and output valids and puts the block
// into wheel mode, which moving speed commands reduce modulo 2048 (modulo
// 1024 after a joint mode command).
// When the receiver holds tx_o.ready low, the byte stays put, the packet
// buffer waits, and cmd_i.ready drops once one more command is latched.
`timescale 1ns / 1ps

module servo_bus_instruction_packet_builder
  import sbpb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  sbpb_cmd_if.sink    cmd_i,
  sbpb_byte_if.source tx_o
);

  pkt_t pkt;
  logic pkt_vld;
  logic pkt_take;

  // command latch and packet assembly
  sbpb_builder u_builder (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd_i),
    .pkt_o      (pkt),
    .pkt_vld_o  (pkt_vld),
    .pkt_take_i (pkt_take)
  );

  // byte output
  sbpb_serializer u_serializer (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pkt_i      (pkt),
    .pkt_vld_i  (pkt_vld),
    .pkt_take_o (pkt_take),
    .tx_o       (tx_o)
  );

endmodule

// ===== tb/sv/servo_bus_instruction_packet_builder_test.sv =====
// testbench: servo packet builder, directed table and random commands against a byte predictor
`timescale 1ns / 1ps

module servo_bus_instruction_packet_builder_test;
  import sbpb_pkg::*;

  // codes the block must ignore
  localparam logic [2:0] OP_SPARE_LO = 3'd6;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;

  // protocol bytes
  localparam logic [7:0] SYNC_BYTE        = 8'hFF;
  localparam logic [7:0] INSTR_READ       = 8'h02;
  localparam logic [7:0] INSTR_WRITE      = 8'h03;
  localparam logic [7:0] REG_ANGLE_LIMITS = 8'h06;
  localparam logic [7:0] REG_MOVING_SPEED = 8'h20;

  // control table below 0x40: one bit per address that reads two or one bytes
  localparam logic [63:0] WORD_REG_MAP = 64'h0001_0155_4000_4141;
  localparam logic [63:0] BYTE_REG_MAP = 64'h0000_DC00_3F07_383C;

  // run shape
  localparam int unsigned RANDOM_CMDS   = 400;
  localparam int unsigned CALM_CMDS     = 60;
  localparam int unsigned HOLD_AT       = 120;
  localparam int unsigned DRAIN_AT      = 260;
  localparam int unsigned LONG_HOLD     = 200;
  localparam int unsigned SETTLE_CYCLES = 24;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned DIRECTED_ROWS = 25;

  typedef struct packed {
    logic [2:0]         op;
    logic [7:0]         servo_id;
    logic [7:0]         reg_addr;
    logic [15:0]        value;
    logic signed [15:0] cw_limit;
    logic [15:0]        ccw_limit;
  } servo_cmd_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } pkt_byte_t;

  // one directed command; fixed rows carry their packet, right-justified, first byte highest
  typedef struct packed {
    logic [2:0]  op;
    logic [7:0]  servo_id;
    logic [7:0]  reg_addr;
    logic [15:0] value;
    logic [15:0] cw_limit;
    logic [15:0] ccw_limit;
    logic        fixed;
    logic [3:0]  nbytes;
    logic [87:0] bytes;
  } stim_row_t;

  localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
    // reads: two-byte, one-byte and unknown addresses
    '{OP_READ_REG,   8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000, 1'b1, 4'd8,
      88'hFFFF_0004_0200_02F7},
    '{OP_READ_REG,   8'h01, 8'h02, 16'h0000, 16'h0000, 16'h0000, 1'b0, 4'd0, 88'h0},
    '{OP_READ_REG,   8'hFE, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 4'd8,
      88'hFFFF_FE04_02FF_00FC},
    '{OP_READ_REG,   8'h7F, 8'h30, 16'h0000, 16'h0000, 16'h0000, 1'b0, 4'd0, 88'h0},
    '{OP_READ_REG,   8'h80, 8'h2F, 16'h0000, 16'h0000, 16'h0000, 1'b0, 4'd0, 88'h0},
    '{OP_READ_REG,   8'h55, 8'h01, 16'h0000, 16'h0000, 16'h0000, 1'b0, 4'd0, 88'h0},
    '{OP_READ_REG,   8'hAA, 8'h40, 16'h0000, 16'h0000, 16'h0000, 1'b0, 4'd0, 88'h0},
    // byte and word writes, high byte of a byte write dropped
    '{OP_WRITE_BYTE, 8'hFF, 8'hFF, 16'hFFFF, 16'h0000, 16'h0000, 1'b1, 4'd8,
      88'hFFFF_FF04_03FF_FFFB},
    '{OP_WRITE_BYTE, 8'h00, 8'h00, 16'h0100, 16'h0000, 16'h0000, 1'b0, 4'd0, 88'h0},
    '{OP_WRITE_WORD, 8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000, 1'b1, 4'd9,
      88'hFFFF_0005_0300_0000_F7},
    '{OP_WRITE_WORD, 8'hFF, 8'hFF, 16'hFFFF, 16'h0000, 16'h0000, 1'b1, 4'd9,
      88'hFFFF_FF05_03FF_FFFF_FB},
    '{OP_WRITE_WORD, 8'h12, 8'h34, 16'hA55A, 16'h0000, 16'h0000, 1'b0, 4'd0, 88'h0},
    // speed right after reset is in wheel mode
    '{OP_SPEED,      8'h03, 8'h00, 16'hFFFF, 16'h0000, 16'h0000, 1'b0, 4'd0, 88'h0},
    '{OP_SPEED,      8'h04, 8'h00, 16'h0800, 16'h0000, 16'h0000, 1'b0, 4'd0, 88'h0},
    // joint mode: negative cw clamps, large ccw wraps
    '{OP_JOINT_MODE, 8'h00, 8'h00, 16'h0000, 16'h8000, 16'hFFFF, 1'b1, 4'd11,
      88'hFFFF_0007_0306_0000_FF03_ED},
    '{OP_SPEED,      8'h00, 8'h00, 16'hFFFF, 16'h0000, 16'h0000, 1'b1, 4'd9,
      88'hFFFF_0005_0320_FF03_D5},
    '{OP_SPEED,      8'h05, 8'h00, 16'h0400, 16'h0000, 16'h0000, 1'b0, 4'd0, 88'h0},
    '{OP_JOINT_MODE, 8'h06, 8'h00, 16'h0000, 16'h7FFF, 16'h03FF, 1'b0, 4'd0, 88'h0},
    '{OP_JOINT_MODE, 8'h07, 8'h00, 16'h0000, 16'hFFFF, 16'h0400, 1'b0, 4'd0, 88'h0},
    '{OP_JOINT_MODE, 8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000, 1'b1, 4'd11,
      88'hFFFF_0007_0306_0000_0000_EF},
    // unused codes send nothing
    '{OP_SPARE_LO,   8'h5A, 8'hA5, 16'hFFFF, 16'h8000, 16'hFFFF, 1'b1, 4'd0, 88'h0},
    '{OP_SPARE_HI,   8'hA5, 8'h5A, 16'h0000, 16'h7FFF, 16'h0000, 1'b1, 4'd0, 88'h0},
    // back to wheel mode
    '{OP_WHEEL_MODE, 8'hFE, 8'h00, 16'hFFFF, 16'h7FFF, 16'hFFFF, 1'b1, 4'd11,
      88'hFFFF_FE07_0306_0000_0000_F1},
    '{OP_SPEED,      8'h08, 8'h00, 16'h0400, 16'h0000, 16'h0000, 1'b0, 4'd0, 88'h0},
    '{OP_SPEED,      8'hFF, 8'h00, 16'h0000, 16'h0000, 16'h0000, 1'b0, 4'd0, 88'h0}
  };

  logic clk = 1'b0;
  logic rst_n;

  sbpb_cmd_if  cmd_if ();
  sbpb_byte_if tx_if ();

  servo_bus_instruction_packet_builder u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cmd_i  (cmd_if),
    .tx_o   (tx_if)
  );

  // predictor state and bookkeeping
  logic        servo_in_joint;
  pkt_byte_t   pending_bytes [$];
  bit          calm;
  bit          hold_req;
  int unsigned cmds_sent;
  int unsigned spare_cmds;
  int unsigned joint_speeds;
  int unsigned bytes_checked;
  int unsigned mismatches;

  // clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // packet predictor: returns the byte count, bytes right-justified with the first one highest
  function automatic int unsigned build_packet(input servo_cmd_t c, output logic [87:0] bytes);
    logic [7:0]  body [BODY_MAX];
    int unsigned nbody;
    int unsigned k;
    logic [7:0]  sum;
    logic [15:0] cw;
    logic [15:0] ccw;
    logic [15:0] speed;
    bytes = '0;
    nbody = 0;
    sum   = '0;
    cw    = c.cw_limit[15] ? 16'd0 : c.cw_limit;
    ccw   = {6'd0, c.ccw_limit[9:0]};
    speed = servo_in_joint ? {6'd0, c.value[9:0]} : {5'd0, c.value[10:0]};
    body[0] = c.servo_id;
    case (c.op)
      OP_READ_REG: begin
        body[1] = 8'd4;
        body[2] = INSTR_READ;
        body[3] = c.reg_addr;
        body[4] = 8'd0;
        if (c.reg_addr[7:6] == 2'b00) begin
          if (WORD_REG_MAP[c.reg_addr[5:0]]) body[4] = 8'd2;
          else if (BYTE_REG_MAP[c.reg_addr[5:0]]) body[4] = 8'd1;
        end
        nbody = 5;
      end
      OP_WRITE_BYTE: begin
        body[1] = 8'd4;
        body[2] = INSTR_WRITE;
        body[3] = c.reg_addr;
        body[4] = c.value[7:0];
        nbody = 5;
      end
      OP_WRITE_WORD: begin
        body[1] = 8'd5;
        body[2] = INSTR_WRITE;
        body[3] = c.reg_addr;
        body[4] = c.value[7:0];
        body[5] = c.value[15:8];
        nbody = 6;
      end
      OP_WHEEL_MODE: begin
        body[1] = 8'd7;
        body[2] = INSTR_WRITE;
        body[3] = REG_ANGLE_LIMITS;
        body[4] = 8'd0;
        body[5] = 8'd0;
        body[6] = 8'd0;
        body[7] = 8'd0;
        servo_in_joint = 1'b0;
        nbody = 8;
      end
      OP_JOINT_MODE: begin
        body[1] = 8'd7;
        body[2] = INSTR_WRITE;
        body[3] = REG_ANGLE_LIMITS;
        body[4] = cw[7:0];
        body[5] = cw[15:8];
        body[6] = ccw[7:0];
        body[7] = ccw[15:8];
        servo_in_joint = 1'b1;
        nbody = 8;
      end
      OP_SPEED: begin
        body[1] = 8'd5;
        body[2] = INSTR_WRITE;
        body[3] = REG_MOVING_SPEED;
        body[4] = speed[7:0];
        body[5] = speed[15:8];
        nbody = 6;
      end
      default: nbody = 0;
    endcase
    if (nbody == 0) return 0;
    // sync bytes, body, then the inverted sum of the body
    bytes = {72'd0, SYNC_BYTE, SYNC_BYTE};
    for (k = 0; k < nbody; k++) begin
      sum   = sum + body[k];
      bytes = {bytes[79:0], body[k]};
    end
    bytes = {bytes[79:0], ~sum};
    return nbody + 3;
  endfunction

  // offer one command, wait for its handshake, queue its packet bytes
  task automatic issue_cmd(input servo_cmd_t c, input bit fixed, input int unsigned fixed_n,
                           input logic [87:0] fixed_bytes);
    logic [87:0] bytes;
    int unsigned n;
    int unsigned k;
    pkt_byte_t   entry;
    cmd_if.valid     <= 1'b1;
    cmd_if.op        <= c.op;
    cmd_if.servo_id  <= c.servo_id;
    cmd_if.reg_addr  <= c.reg_addr;
    cmd_if.value     <= c.value;
    cmd_if.cw_limit  <= c.cw_limit;
    cmd_if.ccw_limit <= c.ccw_limit;
    do @(posedge clk); while (!cmd_if.ready);
    if (c.op == OP_SPEED && servo_in_joint) joint_speeds++;
    if (c.op > OP_SPEED) spare_cmds++;
    cmds_sent++;
    n = build_packet(c, bytes);
    if (fixed) begin
      n     = fixed_n;
      bytes = fixed_bytes;
    end
    for (k = 0; k < n; k++) begin
      entry.data = bytes[8*(n-1-k) +: 8];
      entry.last = (k == n - 1);
      pending_bytes.push_back(entry);
    end
    // random gap on the command side
    if (!calm && $urandom_range(0, 5) == 0) begin
      cmd_if.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  // command stimulus
  initial begin
    servo_cmd_t  c;
    int unsigned counted;
    bit          held;
    bit          drained;
    cmd_if.valid     = 1'b0;
    cmd_if.op        = '0;
    cmd_if.servo_id  = '0;
    cmd_if.reg_addr  = '0;
    cmd_if.value     = '0;
    cmd_if.cw_limit  = '0;
    cmd_if.ccw_limit = '0;
    servo_in_joint   = 1'b0;
    calm             = 1'b0;
    hold_req         = 1'b0;
    cmds_sent        = 0;
    spare_cmds       = 0;
    joint_speeds     = 0;
    counted          = 0;
    held             = 1'b0;
    drained          = 1'b0;
    rst_n            = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      c.op        = DIRECTED[r].op;
      c.servo_id  = DIRECTED[r].servo_id;
      c.reg_addr  = DIRECTED[r].reg_addr;
      c.value     = DIRECTED[r].value;
      c.cw_limit  = DIRECTED[r].cw_limit;
      c.ccw_limit = DIRECTED[r].ccw_limit;
      issue_cmd(c, DIRECTED[r].fixed, DIRECTED[r].nbytes, DIRECTED[r].bytes);
    end

    // random commands; unused codes do not count
    while (counted < RANDOM_CMDS) begin
      if (counted == HOLD_AT && !held) begin
        hold_req = 1'b1;
        held     = 1'b1;
      end
      // let the whole pipeline empty once
      if (counted == DRAIN_AT && !drained) begin
        cmd_if.valid <= 1'b0;
        do @(posedge clk); while (pending_bytes.size() != 0);
        drained = 1'b1;
      end
      if (counted >= RANDOM_CMDS - CALM_CMDS) calm = 1'b1;
      if ($urandom_range(0, 24) == 0) c.op = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
      else c.op = 3'($urandom_range(OP_READ_REG, OP_SPEED));
      case ($urandom_range(0, 7))
        0:       c.servo_id = 8'h00;
        1:       c.servo_id = 8'hFF;
        default: c.servo_id = 8'($urandom);
      endcase
      c.reg_addr = $urandom_range(0, 1) ? 8'($urandom_range(0, 63)) : 8'($urandom);
      if ($urandom_range(0, 7) == 0) begin
        case ($urandom_range(0, 5))
          0:       c.value = 16'h0000;
          1:       c.value = 16'hFFFF;
          2:       c.value = 16'h03FF;
          3:       c.value = 16'h0400;
          4:       c.value = 16'h07FF;
          default: c.value = 16'h0800;
        endcase
      end else begin
        c.value = 16'($urandom);
      end
      c.cw_limit  = 16'($urandom);
      c.ccw_limit = $urandom_range(0, 1) ? 16'($urandom_range(0, 1023)) : 16'($urandom);
      issue_cmd(c, 1'b0, 0, 88'h0);
      if (c.op <= OP_SPEED) counted++;
    end
    cmd_if.valid <= 1'b0;

    // wait for the last packet, then watch for stray bytes
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("covered %0d commands (%0d with unused codes), %0d packet bytes checked",
             cmds_sent, spare_cmds, bytes_checked);
    $display("covered %0d speed commands in joint mode, one long output hold, one full drain",
             joint_speeds);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // byte receiver: random stalls, one long hold on request
  initial begin
    int unsigned stall_left;
    tx_if.ready = 1'b0;
    stall_left  = 0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
        tx_if.ready <= 1'b0;
      end else if (hold_req) begin
        hold_req    = 1'b0;
        stall_left  = LONG_HOLD - 1;
        tx_if.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 6) == 0) begin
        stall_left  = $urandom_range(0, 12);
        tx_if.ready <= 1'b0;
      end else begin
        tx_if.ready <= 1'b1;
      end
    end
  end

  // byte checker
  always @(posedge clk) begin
    pkt_byte_t want;
    if (rst_n && tx_if.valid && tx_if.ready) begin
      if (pending_bytes.size() == 0) begin
        $error("unexpected packet byte: tx_byte %02h last_byte %0b", tx_if.tx_byte,
               tx_if.last_byte);
        mismatches++;
      end else begin
        want = pending_bytes.pop_front();
        bytes_checked++;
        if (tx_if.tx_byte !== want.data) begin
          $error("tx_byte: expected %02h, actual %02h", want.data, tx_if.tx_byte);
          mismatches++;
        end
        if (tx_if.last_byte !== want.last) begin
          $error("last_byte: expected %0b, actual %0b", want.last, tx_if.last_byte);
          mismatches++;
        end
      end
    end
  end

  // watchdog
  initial begin
    int unsigned cycle_count;
    mismatches    = 0;
    bytes_checked = 0;
    cycle_count   = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d bytes still expected", cycle_count,
             pending_bytes.size());
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/sbpb_pkg.sv
rtl/core/sbpb_cmd_if.sv
rtl/core/sbpb_byte_if.sv
rtl/core/sbpb_builder.sv
rtl/core/sbpb_serializer.sv
rtl/core/servo_bus_instruction_packet_builder.sv
tb/sv/servo_bus_instruction_packet_builder_test.sv
